// ----- design/tsvcg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tsvcg_pkg;

  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] CFG_RATE     = 3'd3;
  localparam logic [2:0] CFG_ROWS     = 3'd4;
  localparam logic [2:0] CFG_COLS     = 3'd5;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BELOW   = 2'd1;
  localparam logic [1:0] STAT_OUTSIDE = 2'd2;
  localparam logic [1:0] STAT_SAT     = 2'd3;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // classified transaction handed from front to back
  typedef struct packed {
    logic        is_read;
    logic        outside;
    logic [23:0] idx;
    logic [31:0] h;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } tsvcg_entry_t;

endpackage
`default_nettype wire

// ----- design/tsvcg_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tsvcg_front import tsvcg_pkg::*; #(
  parameter int GRID_ROWS   = 256,
  parameter int GRID_COLS   = 256,
  parameter int HEIGHT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_cmd,
  input  wire logic signed [31:0] in_coord_x,
  input  wire logic signed [31:0] in_coord_y,
  input  wire logic signed [31:0] in_coord_z,
  input  wire logic [7:0]         in_blue,
  input  wire logic [7:0]         in_green,
  input  wire logic [7:0]         in_red,
  input  wire logic [7:0]         in_read_row,
  input  wire logic [7:0]         in_read_col,
  input  wire logic [31:0]        origin_x,
  input  wire logic [31:0]        origin_y,
  input  wire logic [31:0]        origin_z,
  input  wire logic [31:0]        rate,
  input  wire logic [12:0]        nrows,
  input  wire logic [12:0]        ncols,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output tsvcg_entry_t            q_data
);

  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_MUL   = 2'd1;
  localparam logic [1:0] F_CLASS = 2'd2;
  localparam logic [1:0] F_PUSH  = 2'd3;

  logic [1:0]   state_r, state_nxt;
  logic [1:0]   mcnt_r, mcnt_nxt;
  logic [31:0]  dx_r, dy_r, dz_r;
  logic [31:0]  row_r, col_r, h_r;
  logic [7:0]   b_r, g_r, rd_r;
  tsvcg_entry_t entry_r;

  logic         accept;
  logic [32:0]  dx, dy, dz;
  logic [31:0]  op;
  logic [63:0]  prod;
  logic         rd_out;
  logic [31:0]  rd_idx, add_idx;
  logic         add_out;
  logic [31:0]  hshift;

  assign in_ready = (state_r == F_IDLE) && en;
  assign accept   = in_valid && in_ready;
  assign q_valid  = (state_r == F_PUSH);
  assign q_data   = entry_r;

  assign dx = {in_coord_x[31], in_coord_x} - {origin_x[31], origin_x};
  assign dy = {in_coord_y[31], in_coord_y} - {origin_y[31], origin_y};
  assign dz = {in_coord_z[31], in_coord_z} - {origin_z[31], origin_z};

  assign rd_out = ({5'd0, in_read_row} >= nrows) || ({5'd0, in_read_col} >= ncols);
  assign rd_idx = 32'(in_read_row) * 32'(GRID_COLS) + 32'(in_read_col);

  always_comb begin
    unique case (mcnt_r)
      2'd0:    op = dx_r;
      2'd1:    op = dy_r;
      default: op = dz_r;
    endcase
  end
  assign prod = 64'(op) * 64'(rate);

  assign hshift  = h_r >> HEIGHT_BITS;
  assign add_out = (row_r >= 32'(nrows)) || (col_r >= 32'(ncols)) || (hshift != 32'd0);
  assign add_idx = row_r * 32'(GRID_COLS) + col_r;

  always_comb begin
    state_nxt = state_r;
    mcnt_nxt  = mcnt_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_READ || dx[32] || dy[32] || dz[32]) begin
            state_nxt = F_PUSH;
          end else begin
            state_nxt = F_MUL;
            mcnt_nxt  = 2'd0;
          end
        end
      end
      F_MUL: begin
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'd2) begin
          state_nxt = F_CLASS;
        end
      end
      F_CLASS: state_nxt = F_PUSH;
      default: begin
        if (q_ready) begin
          state_nxt = F_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      mcnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      mcnt_r  <= mcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx_r          <= dx[31:0];
      dy_r          <= dy[31:0];
      dz_r          <= dz[31:0];
      b_r           <= in_blue;
      g_r           <= in_green;
      rd_r          <= in_red;
      entry_r.is_read <= (in_cmd == CMD_READ);
      entry_r.outside <= (in_cmd == CMD_READ) ? rd_out : 1'b1;
      entry_r.idx     <= rd_idx[23:0];
      entry_r.h       <= 32'd0;
      entry_r.blue    <= in_blue;
      entry_r.green   <= in_green;
      entry_r.red     <= in_red;
    end
    if (state_r == F_MUL) begin
      unique case (mcnt_r)
        2'd0:    row_r <= prod[63:32];
        2'd1:    col_r <= prod[63:32];
        default: h_r   <= {1'b0, prod[63:33]};
      endcase
    end
    if (state_r == F_CLASS) begin
      entry_r.is_read <= 1'b0;
      entry_r.outside <= add_out;
      entry_r.idx     <= add_idx[23:0];
      entry_r.h       <= h_r;
      entry_r.blue    <= b_r;
      entry_r.green   <= g_r;
      entry_r.red     <= rd_r;
    end
  end

endmodule
`default_nettype wire

// ----- design/tsvcg_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tsvcg_queue import tsvcg_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire tsvcg_entry_t  push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output tsvcg_entry_t       pop_data
);

  tsvcg_entry_t slot_r [2];
  logic         wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- design/tsvcg_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tsvcg_back import tsvcg_pkg::*; #(
  parameter int GRID_ROWS   = 256,
  parameter int GRID_COLS   = 256,
  parameter int HEIGHT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  output logic             clear_done,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire tsvcg_entry_t q_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic             out_occupied,
  output logic [15:0]      out_top_height,
  output logic [7:0]       out_blue_avg,
  output logic [7:0]       out_green_avg,
  output logic [7:0]       out_red_avg
);

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int HB    = HEIGHT_BITS;

  localparam logic [2:0] B_CLEAR = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_RD    = 3'd2;
  localparam logic [2:0] B_UPD   = 3'd3;
  localparam logic [2:0] B_DIV   = 3'd4;
  localparam logic [2:0] B_OUT   = 3'd5;

  typedef struct packed {
    logic [HB-1:0] height;
    logic [15:0]   count;
    logic [23:0]   bsum;
    logic [23:0]   gsum;
    logic [23:0]   rsum;
  } cell_t;

  cell_t        mem [CELLS];
  cell_t        rdata_r;
  logic         mem_we;
  logic [IDX_W-1:0] waddr;
  cell_t        wdata;

  logic [2:0]   state_r, state_nxt;
  logic [IDX_W-1:0] clr_r;
  tsvcg_entry_t e_r;
  cell_t        cell_r;
  logic [1:0]   stat_r;
  logic [4:0]   dcnt_r;
  logic [23:0]  nb_r, ng_r, nr_r;
  logic [15:0]  rb_r, rg_r, rr_r;

  cell_t        upd_cell;
  logic [1:0]   upd_stat;
  logic         upd_we;
  logic [HB-1:0] hh;
  logic [31:0]  h32;

  logic [39:0]  sb, sg, sr;

  function automatic logic [39:0] div_step(input logic [23:0] num, input logic [15:0] rem,
                                           input logic [15:0] den);
    logic [16:0] t;
    logic [16:0] d;
    logic        qb;
    t = {rem, num[23]};
    d = t - {1'b0, den};
    qb = (t >= {1'b0, den});
    return {(qb ? d[15:0] : t[15:0]), num[22:0], qb};
  endfunction

  assign clear_done = (state_r != B_CLEAR);
  assign q_ready    = (state_r == B_IDLE);
  assign out_valid  = (state_r == B_OUT);

  assign hh = e_r.h[HB-1:0];

  always_comb begin
    upd_cell = rdata_r;
    upd_stat = STAT_OK;
    upd_we   = 1'b0;
    if (!e_r.is_read) begin
      if (rdata_r.count == 16'd0 || hh > rdata_r.height) begin
        upd_cell.height = hh;
        upd_cell.count  = 16'd1;
        upd_cell.bsum   = 24'(e_r.blue);
        upd_cell.gsum   = 24'(e_r.green);
        upd_cell.rsum   = 24'(e_r.red);
        upd_we          = 1'b1;
      end else if (hh < rdata_r.height) begin
        upd_stat = STAT_BELOW;
      end else if (rdata_r.count == 16'hFFFF) begin
        upd_stat = STAT_SAT;
      end else begin
        upd_cell.count = rdata_r.count + 16'd1;
        upd_cell.bsum  = rdata_r.bsum + 24'(e_r.blue);
        upd_cell.gsum  = rdata_r.gsum + 24'(e_r.green);
        upd_cell.rsum  = rdata_r.rsum + 24'(e_r.red);
        upd_we         = 1'b1;
      end
    end
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = e_r.idx[IDX_W-1:0];
    wdata  = upd_cell;
    if (state_r == B_CLEAR) begin
      mem_we = 1'b1;
      waddr  = clr_r;
      wdata  = '0;
    end else if (state_r == B_UPD) begin
      mem_we = upd_we;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[e_r.idx[IDX_W-1:0]];
  end

  assign sb = div_step(nb_r, rb_r, cell_r.count);
  assign sg = div_step(ng_r, rg_r, cell_r.count);
  assign sr = div_step(nr_r, rr_r, cell_r.count);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_CLEAR: begin
        if (clr_r == IDX_W'(CELLS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid) begin
          state_nxt = q_data.outside ? B_OUT : B_RD;
        end
      end
      B_RD:  state_nxt = B_UPD;
      B_UPD: state_nxt = (upd_cell.count == 16'd0) ? B_OUT : B_DIV;
      B_DIV: begin
        if (dcnt_r == 5'd23) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (out_ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLEAR) begin
        clr_r <= clr_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          e_r    <= q_data;
          stat_r <= q_data.outside ? STAT_OUTSIDE : STAT_OK;
          cell_r <= '0;
          nb_r   <= '0;
          ng_r   <= '0;
          nr_r   <= '0;
        end
      end
      B_UPD: begin
        cell_r <= upd_cell;
        stat_r <= upd_stat;
        nb_r   <= upd_cell.bsum;
        ng_r   <= upd_cell.gsum;
        nr_r   <= upd_cell.rsum;
        rb_r   <= '0;
        rg_r   <= '0;
        rr_r   <= '0;
        dcnt_r <= 5'd0;
      end
      B_DIV: begin
        {rb_r, nb_r} <= sb;
        {rg_r, ng_r} <= sg;
        {rr_r, nr_r} <= sr;
        dcnt_r       <= dcnt_r + 5'd1;
      end
      default: begin
      end
    endcase
  end

  assign h32            = 32'(cell_r.height);
  assign out_status     = stat_r;
  assign out_occupied   = (cell_r.count != 16'd0);
  assign out_top_height = h32[15:0];
  assign out_blue_avg   = nb_r[7:0];
  assign out_green_avg  = ng_r[7:0];
  assign out_red_avg    = nr_r[7:0];

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CLEAR) |-> !q_ready)
    else $error("queue popped during clear");
  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == B_CLEAR || state_r == B_UPD))
    else $error("memory written outside clear or update");
  a_outside_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && stat_r == STAT_OUTSIDE) |-> !out_occupied)
    else $error("outside result carries cell data");
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV && dcnt_r == 5'd23) |=> (state_r == B_OUT))
    else $error("divider did not finish");

endmodule
`default_nettype wire

// ----- design/top_surface_voxel_color_grid.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Top-surface color grid: add commands bin a colored point into a cell and keep
// the color average of its highest layer; read commands return a cell's state.
// Every transaction returns exactly one result. After reset the cell memory is
// cleared, one entry a cycle, before in_ready rises. An add inside the grid
// passes the front, which forms row, column and height in turn on its one shared
// 32x32 multiplier, and then the back: a memory read, an update and the
// bit-serial divider that forms the averages. Reads of occupied cells also take
// the memory read, the update and the divider. Reads of empty cells skip the
// divider, and results outside the grid skip the memory and divider.
module top_surface_voxel_color_grid import tsvcg_pkg::*; #(
  parameter int GRID_ROWS   = 256,
  parameter int GRID_COLS   = 256,
  parameter int HEIGHT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_addr,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_cmd,
  input  wire logic signed [31:0] in_coord_x,
  input  wire logic signed [31:0] in_coord_y,
  input  wire logic signed [31:0] in_coord_z,
  input  wire logic [7:0]         in_blue,
  input  wire logic [7:0]         in_green,
  input  wire logic [7:0]         in_red,
  input  wire logic [7:0]         in_read_row,
  input  wire logic [7:0]         in_read_col,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic                    out_occupied,
  output logic [15:0]             out_top_height,
  output logic [7:0]              out_blue_avg,
  output logic [7:0]              out_green_avg,
  output logic [7:0]              out_red_avg
);

  logic [31:0] origin_x_r, origin_y_r, origin_z_r, rate_r;
  logic [8:0]  rows_r, cols_r;
  logic [12:0] nrows, ncols;
  logic        clear_done;
  logic        fq_valid, fq_ready, bq_valid, bq_ready;
  tsvcg_entry_t fq_data, bq_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= 32'd0;
      origin_y_r <= 32'd0;
      origin_z_r <= 32'd0;
      rate_r     <= 32'd1310720;
      rows_r     <= 9'd256;
      cols_r     <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ORIGIN_X: origin_x_r <= cfg_wdata;
        CFG_ORIGIN_Y: origin_y_r <= cfg_wdata;
        CFG_ORIGIN_Z: origin_z_r <= cfg_wdata;
        CFG_RATE:     rate_r     <= cfg_wdata;
        CFG_ROWS:     rows_r     <= cfg_wdata[8:0];
        CFG_COLS:     cols_r     <= cfg_wdata[8:0];
        default: begin
        end
      endcase
    end
  end

  assign nrows = (13'(rows_r) < 13'(GRID_ROWS)) ? 13'(rows_r) : 13'(GRID_ROWS);
  assign ncols = (13'(cols_r) < 13'(GRID_COLS)) ? 13'(cols_r) : 13'(GRID_COLS);

  tsvcg_front #(
    .GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS), .HEIGHT_BITS(HEIGHT_BITS)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .en(clear_done),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .in_read_row(in_read_row), .in_read_col(in_read_col),
    .origin_x(origin_x_r), .origin_y(origin_y_r), .origin_z(origin_z_r),
    .rate(rate_r), .nrows(nrows), .ncols(ncols),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  tsvcg_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(fq_valid), .push_ready(fq_ready), .push_data(fq_data),
    .pop_valid(bq_valid), .pop_ready(bq_ready), .pop_data(bq_data)
  );

  tsvcg_back #(
    .GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS), .HEIGHT_BITS(HEIGHT_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .clear_done(clear_done),
    .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_occupied(out_occupied), .out_top_height(out_top_height),
    .out_blue_avg(out_blue_avg), .out_green_avg(out_green_avg),
    .out_red_avg(out_red_avg)
  );

endmodule
`default_nettype wire
